FILE: src/rrr_pkg.sv
package rrr_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int IN_TDATA_W  = 168;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;

    localparam logic [15:0] SLACK_RESET = 16'd16;

    // Action codes carried in the input tuser.
    localparam logic [1:0] ACT_REMEMBER = 2'd0;
    localparam logic [1:0] ACT_ZONE     = 2'd1;
    localparam logic [1:0] ACT_RESTORE  = 2'd2;
    localparam logic [1:0] ACT_FORGET   = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_CHANGED   = 2'd3;

    typedef struct packed {
        logic        [15:0] h;
        logic        [15:0] w;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } rect_t;

    typedef struct packed {
        logic [3:0] zone_in;
        rect_t      rect;
        rect_t      pre;
        logic [31:0] key;
    } item_t;

    typedef struct packed {
        logic        pad;
        rect_t       orig;
        logic [3:0]  zone_out;
        logic        zone_found;
        logic [1:0]  status;
    } result_t;

endpackage

FILE: src/rect_restore_registry.sv
// Registry of SLOT_COUNT slots keyed by a 32-bit handle. Each item on the input stream carries
// an action in tuser (remember, zone query, restore, forget) and its operands in tdata; each
// item gives exactly one result item. A single comparator walks the key store one slot per
// cycle, and a restore that finds its key then has one shared subtract-and-compare unit check
// x, y, w and h against restore_slack in turn. The next item is accepted only after the
// current result is loaded for output. A waiting result does not block the next item unless
// a second result is ready before the first is taken. restore_slack is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, which the block
// itself does not enforce. The slot table comes out of reset empty.
module rect_restore_registry
    import rrr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // key, pre_x, pre_y, pre_w, pre_h, rect_x, rect_y, rect_w, rect_h, zone_in, zero pad
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // action
    input  logic [IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // status, zone_found, zone_out, out_x, out_y, out_w, out_h, zero pad
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                    cfg_we,
    input  logic [15:0]             cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(SLOT_COUNT - 1);

    logic [2:0]             state_reg, state_next;
    logic [SLOT_COUNT-1:0]  valid_reg, valid_next;
    logic [15:0]            slack_reg;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_data_reg;

    item_t                  item_reg;
    logic [1:0]             action_reg;
    logic [SLOT_IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic                   cmp_pend_reg, cmp_pend_next;
    logic [SLOT_IDX_W-1:0]  cmp_idx_reg;
    logic                   hit_reg, hit_next;
    logic [SLOT_IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic                   free_reg, free_next;
    logic [SLOT_IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [1:0]             coord_reg, coord_next;
    logic                   ok_reg, ok_next;

    // Slot stores: one read address and one write address per cycle.
    logic [31:0]            key_mem   [SLOT_COUNT];
    rect_t                  orig_mem  [SLOT_COUNT];
    rect_t                  plac_mem  [SLOT_COUNT];
    logic [3:0]             zone_mem  [SLOT_COUNT];
    logic [31:0]            key_rd_reg;
    rect_t                  orig_rd_reg;
    rect_t                  plac_rd_reg;
    logic [3:0]             zone_rd_reg;

    logic [SLOT_IDX_W-1:0]  rd_addr;
    logic [SLOT_IDX_W-1:0]  wr_addr;
    logic                   wr_upd;
    logic                   wr_ins;

    logic                   in_accept;
    logic                   out_load;
    logic signed [16:0]     cmp_a;
    logic signed [16:0]     cmp_b;
    logic signed [16:0]     diff;
    logic [16:0]            mag;
    logic                   coord_ok;
    result_t                res;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign rd_addr       = (state_reg == S_SCAN) ? scan_idx_reg : hit_idx_reg;

    // Shared coordinate unit: x and y compare as signed, w and h as unsigned.
    always_comb
    begin
        case (coord_reg)
            2'd0:
            begin
                cmp_a = {item_reg.rect.x[15], item_reg.rect.x};
                cmp_b = {plac_rd_reg.x[15], plac_rd_reg.x};
            end
            2'd1:
            begin
                cmp_a = {item_reg.rect.y[15], item_reg.rect.y};
                cmp_b = {plac_rd_reg.y[15], plac_rd_reg.y};
            end
            2'd2:
            begin
                cmp_a = {1'b0, item_reg.rect.w};
                cmp_b = {1'b0, plac_rd_reg.w};
            end
            default:
            begin
                cmp_a = {1'b0, item_reg.rect.h};
                cmp_b = {1'b0, plac_rd_reg.h};
            end
        endcase
        diff     = cmp_a - cmp_b;
        mag      = diff[16] ? 17'(-diff) : 17'(diff);
        coord_ok = (mag <= {1'b0, slack_reg});
    end

    // Result of the finished item and the table updates that go with it.
    always_comb
    begin
        res        = '0;
        valid_next = valid_reg;
        wr_addr    = hit_idx_reg;
        wr_upd     = 1'b0;
        wr_ins     = 1'b0;
        case (action_reg)
            ACT_REMEMBER:
            begin
                if (hit_reg)
                begin
                    wr_upd = 1'b1;
                end
                else if (free_reg)
                begin
                    wr_addr = free_idx_reg;
                    wr_upd  = 1'b1;
                    wr_ins  = 1'b1;
                    valid_next[free_idx_reg] = 1'b1;
                end
                else
                begin
                    res.status = STAT_FULL;
                end
            end
            ACT_ZONE:
            begin
                if (hit_reg)
                begin
                    res.zone_found = 1'b1;
                    res.zone_out   = zone_rd_reg;
                end
                else
                begin
                    res.status = STAT_NOT_FOUND;
                end
            end
            ACT_RESTORE:
            begin
                if (!hit_reg)
                begin
                    res.status = STAT_NOT_FOUND;
                end
                else
                begin
                    if (ok_reg)
                    begin
                        res.orig = orig_rd_reg;
                    end
                    else
                    begin
                        res.status = STAT_CHANGED;
                    end
                    valid_next[hit_idx_reg] = 1'b0;
                end
            end
            default:
            begin
                if (hit_reg)
                begin
                    valid_next[hit_idx_reg] = 1'b0;
                end
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_pend_next  = 1'b0;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        coord_next     = coord_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        // The key read for a slot is registered, so it lands in the cycle after its address was issued.
        if (cmp_pend_reg)
        begin
            if (valid_reg[cmp_idx_reg] && (key_rd_reg == item_reg.key) && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx_reg;
            end
            if (!valid_reg[cmp_idx_reg] && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = cmp_idx_reg;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next    = S_SCAN;
                    scan_idx_next = '0;
                    hit_next      = 1'b0;
                    hit_idx_next  = '0;
                    free_next     = 1'b0;
                    free_idx_next = '0;
                    coord_next    = 2'd0;
                    ok_next       = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmp_pend_next = 1'b1;
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                if ((action_reg == ACT_RESTORE) && hit_reg)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CHECK:
            begin
                ok_next    = ok_reg && coord_ok;
                coord_next = coord_reg + 2'd1;
                if (coord_reg == 2'd3)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            slack_reg     <= SLACK_RESET;
            out_valid_reg <= 1'b0;
            cmp_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cmp_pend_reg  <= cmp_pend_next;
            if ((state_reg == S_DONE) && out_load)
            begin
                valid_reg <= valid_next;
            end
            if (cfg_we)
            begin
                slack_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg   <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
            action_reg <= s_axis_tuser[1:0];
        end
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= scan_idx_reg;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        coord_reg    <= coord_next;
        ok_reg       <= ok_next;
        if ((state_reg == S_DONE) && out_load)
        begin
            out_data_reg <= res;
        end
    end

    // Slot stores.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_load)
        begin
            if (wr_upd)
            begin
                plac_mem[wr_addr] <= item_reg.rect;
                zone_mem[wr_addr] <= item_reg.zone_in;
            end
            if (wr_ins)
            begin
                key_mem[wr_addr]  <= item_reg.key;
                orig_mem[wr_addr] <= item_reg.pre;
            end
        end
        key_rd_reg  <= key_mem[rd_addr];
        orig_rd_reg <= orig_mem[rd_addr];
        plac_rd_reg <= plac_mem[rd_addr];
        zone_rd_reg <= zone_mem[rd_addr];
    end

endmodule

FILE: src/rrr_checker.sv
module rrr_checker
    import rrr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    // A matched zone query always reports success.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == STAT_OK)
        else $error("zone_found set on a failing result");

    // The zone field is clear unless a zone was found.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[6:3] == 4'd0)
        else $error("zone_out set without zone_found");

    // A failing result never carries a rectangle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != STAT_OK) |-> m_axis_tdata[70:7] == 64'd0)
        else $error("rectangle present on a failing result");

    // The block works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready straight after an accepted item");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or was dropped");

endmodule

bind rect_restore_registry rrr_checker u_rrr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
